[rtl/sma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared constants, types and helpers for the segmented memory access unit.
// ----------------------------------------------------------------------------
package sma_pkg;

    // Storage and sizing
    localparam int MEM_BYTES = 16384;
    localparam int SEG_COUNT = 8;
    localparam int DESC_REGS = 8;
    localparam int DESC_IW   = $clog2(DESC_REGS);
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;
    localparam int CFG_IW    = 8;

    // Fault codes as seen on fault_code
    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_SEGMENT = 2'd1,
        FAULT_LIMIT   = 2'd2,
        FAULT_MEMORY  = 2'd3
    } sma_fault_t;

    // Request fields handed to the translation unit
    typedef struct packed {
        logic [15:0]      sel;
        logic [15:0]      off;
        logic [CNT_W-1:0] cnt;
    } sma_xlat_req_t;

    // Translation outcome
    typedef struct packed {
        logic [16:0] phys;
        sma_fault_t  fault;
    } sma_xlat_rsp_t;

    // Byte-wide memory access
    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } sma_mem_req_t;

    // Sign-extend the low 8*n bits of v; zero or full counts pass through
    function automatic logic [31:0] sign_ext(input logic [31:0] v, input logic [CNT_W-1:0] n);
        logic [31:0] r;
        r = v;
        case (n)
            3'd1:    r = {{24{v[7]}}, v[7:0]};
            3'd2:    r = {{16{v[15]}}, v[15:0]};
            3'd3:    r = {{8{v[23]}}, v[23:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

[rtl/sma_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/sma_xlat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_xlat
// Segment descriptor registers and base/limit translation with fault checks.
// ----------------------------------------------------------------------------
module sma_xlat (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sma_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                cfg_data,
    input  sma_pkg::sma_xlat_req_t     req,
    output sma_pkg::sma_xlat_rsp_t     rsp
);
    import sma_pkg::*;

    logic [31:0]      desc_reg [DESC_REGS];
    logic [31:0]      desc;
    logic [15:0]      base;
    logic [15:0]      size;
    logic             seg_ok;
    logic [16:0]      phys;
    logic [CNT_W-1:0] extra;
    logic [17:0]      last;

    // Descriptor writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DESC_REGS; i++)
            begin
                desc_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IW'(DESC_REGS)))
        begin
            desc_reg[cfg_index[DESC_IW-1:0]] <= cfg_data;
        end
    end

    // Select the descriptor and form base + offset
    assign seg_ok = (req.sel < 16'(SEG_COUNT));
    assign desc   = desc_reg[req.sel[DESC_IW-1:0]];
    assign base   = desc[31:16];
    assign size   = desc[15:0];
    assign phys   = {1'b0, base} + {1'b0, req.off};
    assign extra  = (req.cnt == '0) ? '0 : req.cnt - CNT_W'(1);
    assign last   = {1'b0, phys} + 18'(extra);

    // Check faults in priority order
    always_comb
    begin
        rsp.phys  = phys;
        rsp.fault = FAULT_NONE;
        if (!seg_ok)
        begin
            rsp.phys  = '0;
            rsp.fault = FAULT_SEGMENT;
        end
        else if (req.off >= size)
        begin
            rsp.fault = FAULT_LIMIT;
        end
        else if (last >= 18'(MEM_BYTES))
        begin
            rsp.fault = FAULT_MEMORY;
        end
    end

endmodule

[rtl/sma_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_ctrl
// Request sequencer: latches a request, takes the translation, then moves
// one byte a cycle through the byte-wide memory and returns the result.
// ----------------------------------------------------------------------------
module sma_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   req_type,
    input  logic [15:0]            segment,
    input  logic [15:0]            offset,
    input  logic [15:0]            byte_count,
    input  logic [31:0]            write_data,
    output sma_pkg::sma_xlat_req_t xlat_req,
    input  sma_pkg::sma_xlat_rsp_t xlat_rsp,
    output sma_pkg::sma_mem_req_t  mem_req,
    input  logic [7:0]             mem_rdata,
    output logic                   done,
    output logic signed [31:0]     read_data,
    output logic [16:0]            phys_address,
    output logic [1:0]             fault_code
);
    import sma_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XLAT,
        ST_ACCESS
    } state_t;

    state_t            state_reg;
    logic              is_write_reg;
    logic [15:0]       sel_reg;
    logic [15:0]       off_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [31:0]       wdata_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic [CNT_W-1:0]  issued_reg;
    logic [CNT_W-1:0]  got_reg;
    logic              rd_valid_reg;
    logic [31:0]       acc_reg;
    logic              done_reg;
    logic [31:0]       read_data_reg;
    logic [16:0]       phys_reg;
    logic [1:0]        fault_reg;

    logic [CNT_W-1:0]  cnt_clamp;
    logic              issuing;
    logic [1:0]        byte_sel;
    logic [31:0]       acc_next;

    // Clamp the byte count
    assign cnt_clamp = (byte_count > 16'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : byte_count[CNT_W-1:0];

    assign xlat_req.sel = sel_reg;
    assign xlat_req.off = off_reg;
    assign xlat_req.cnt = cnt_reg;

    // Drive the memory: writes send the most significant remaining byte first
    assign issuing       = (state_reg == ST_ACCESS) && (issued_reg < cnt_reg);
    assign byte_sel      = 2'(cnt_reg - CNT_W'(1) - issued_reg);
    assign mem_req.we    = issuing && is_write_reg;
    assign mem_req.addr  = addr_reg;
    assign mem_req.wdata = 8'(wdata_reg >> {byte_sel, 3'b000});

    assign acc_next = {acc_reg[23:0], mem_rdata};

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign phys_address = phys_reg;
    assign fault_code   = fault_reg;

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            issued_reg   <= '0;
            got_reg      <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            rd_valid_reg <= issuing && !is_write_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        is_write_reg <= req_type;
                        sel_reg      <= segment;
                        off_reg      <= offset;
                        cnt_reg      <= cnt_clamp;
                        wdata_reg    <= write_data;
                        state_reg    <= ST_XLAT;
                    end
                end
                ST_XLAT:
                begin
                    phys_reg      <= xlat_rsp.phys;
                    fault_reg     <= xlat_rsp.fault;
                    read_data_reg <= '0;
                    addr_reg      <= xlat_rsp.phys[MEM_AW-1:0];
                    issued_reg    <= '0;
                    got_reg       <= '0;
                    acc_reg       <= '0;
                    if ((xlat_rsp.fault != FAULT_NONE) || (cnt_reg == '0))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    // Advance the address while bytes remain to issue
                    if (issuing)
                    begin
                        addr_reg   <= addr_reg + MEM_AW'(1);
                        issued_reg <= issued_reg + CNT_W'(1);
                    end
                    if (is_write_reg)
                    begin
                        if (issued_reg == cnt_reg - CNT_W'(1))
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (rd_valid_reg)
                    begin
                        // Shift in each returned byte, finish on the last one
                        acc_reg <= acc_next;
                        got_reg <= got_reg + CNT_W'(1);
                        if (got_reg == cnt_reg - CNT_W'(1))
                        begin
                            read_data_reg <= sign_ext(acc_next, cnt_reg);
                            done_reg      <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/segmented_memory_access_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_memory_access_unit_top
// Segment base/limit translation in front of a byte-wide data memory.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   start & !busy             req_type, segment, offset, byte_count,
//                                      write_data
//  result    done (one cycle)          read_data, phys_address, fault_code
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
//  A request is translated first, then moves one byte per cycle through the
//  single memory port; a read finishes once its last byte has returned from
//  the registered RAM. A fault or a zero count finishes straight after
//  translation, with no memory access; busy drops with done.
//  Reset clears the descriptors to zero; the data memory is not cleared.
//  The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module segmented_memory_access_unit_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       req_type,
    input  logic [15:0]                segment,
    input  logic [15:0]                offset,
    input  logic [15:0]                byte_count,
    input  logic [31:0]                write_data,
    output logic                       done,
    output logic signed [31:0]         read_data,
    output logic [16:0]                phys_address,
    output logic [1:0]                 fault_code,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sma_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                cfg_data
);
    import sma_pkg::*;

    sma_xlat_req_t xlat_req;
    sma_xlat_rsp_t xlat_rsp;
    sma_mem_req_t  mem_req;
    logic [7:0]    mem_rdata;

    // Descriptors and translation
    sma_xlat u_xlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (xlat_req),
        .rsp       (xlat_rsp)
    );

    // Byte-wide data memory
    sma_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // Request sequencer
    sma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .segment      (segment),
        .offset       (offset),
        .byte_count   (byte_count),
        .write_data   (write_data),
        .xlat_req     (xlat_req),
        .xlat_rsp     (xlat_rsp),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .done         (done),
        .read_data    (read_data),
        .phys_address (phys_address),
        .fault_code   (fault_code)
    );

endmodule

[rtl/sma_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_chk
// Port-level checks for the segmented memory access unit, bound to the top.
// ----------------------------------------------------------------------------
module sma_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] read_data,
    input logic [16:0]        phys_address,
    input logic [1:0]         fault_code
);
    import sma_pkg::*;

    // An accepted request keeps the unit busy and yields no result next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not hold the unit busy");

    // Results never come on back-to-back cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // A faulted request returns zero read data
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault_code != FAULT_NONE)) |-> (read_data == '0))
        else $error("read data not zero on a fault");

    // A bad selector reports no physical address
    a_badseg_phys: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault_code == FAULT_SEGMENT)) |-> (phys_address == '0))
        else $error("physical address not zero on a bad segment");

    // Busy falls only when a result is shown
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

endmodule

bind segmented_memory_access_unit_top sma_chk u_sma_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segmented memory access unit: loads segment
// descriptor layouts, issues directed and random read/write requests with
// random gaps, and checks every translated result against an in-bench
// predictor that mirrors descriptor state and written memory bytes.
// ----------------------------------------------------------------------------
module testbench;

    import sma_pkg::*;

    localparam logic       ACCESS_READ      = 1'b0;
    localparam logic       ACCESS_WRITE     = 1'b1;
    localparam logic [7:0] STRAY_INDEX_LOW  = 8'(DESC_REGS);
    localparam logic [7:0] STRAY_INDEX_HIGH = 8'hFF;
    localparam int         PHASE_ITEMS      = 190;
    localparam int         QUIET_ITEMS      = 150;
    localparam int         SETTLE_CYCLES    = 12;
    localparam int         HISTORY_DEPTH    = 16;
    localparam int         PRINT_LIMIT      = 40;

    typedef enum {
        LAYOUT_SHARED,
        LAYOUT_COMPACT,
        LAYOUT_WILD,
        LAYOUT_EDGE
    } layout_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] segment;
        logic [15:0] offset;
        logic [15:0] byte_count;
        logic [31:0] write_data;
    } mem_request_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [16:0]        phys_address;
        sma_fault_t         fault_code;
    } access_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: descriptor copy, memory image and outstanding results
    // ------------------------------------------------------------------------
    class access_scoreboard;
        logic [31:0]    desc [DESC_REGS];
        logic [7:0]     mem_image [MEM_BYTES];
        bit             filled [MEM_BYTES];
        access_result_t awaiting_results [$];
        mem_request_t   recent_writes [$];
        int             errors;

        function new();
            foreach (desc[i]) desc[i] = '0;
            foreach (filled[i]) filled[i] = 1'b0;
            errors = 0;
        endfunction

        function void write_desc(input logic [7:0] idx, input logic [31:0] value);
            // indexes past the descriptor file are dropped
            if (idx < DESC_REGS)
                desc[idx] = value;
        endfunction

        // Translate a request; commit stores write bytes, blank flags a read
        // that would touch bytes never written
        function access_result_t translate(input mem_request_t r, input bit commit,
                                           output bit blank);
            access_result_t res;
            int unsigned    cnt, base, size, phys, last;
            logic [31:0]    value;
            res.read_data    = '0;
            res.phys_address = '0;
            res.fault_code   = FAULT_NONE;
            blank            = 1'b0;
            cnt = (r.byte_count > MAX_BYTES) ? MAX_BYTES : 32'(r.byte_count);
            if (r.segment >= SEG_COUNT)
            begin
                res.fault_code = FAULT_SEGMENT;
                return res;
            end
            base = 32'(desc[r.segment][31:16]);
            size = 32'(desc[r.segment][15:0]);
            phys = base + 32'(r.offset);
            last = phys + ((cnt != 0) ? cnt - 1 : 0);
            res.phys_address = phys[16:0];
            if (r.offset >= size)
                res.fault_code = FAULT_LIMIT;
            else if (last >= MEM_BYTES)
                res.fault_code = FAULT_MEMORY;
            else if (r.req_type == ACCESS_WRITE)
            begin
                // store big-endian: most significant of the low cnt bytes first
                if (commit)
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        mem_image[phys + i] = r.write_data[8 * (cnt - 1 - i) +: 8];
                        filled[phys + i]    = 1'b1;
                    end
                end
            end
            else
            begin
                value = '0;
                for (int i = 0; i < cnt; i++)
                begin
                    if (!filled[phys + i])
                        blank = 1'b1;
                    value = {value[23:0], mem_image[phys + i]};
                end
                case (cnt)
                    1:       value = {{24{value[7]}}, value[7:0]};
                    2:       value = {{16{value[15]}}, value[15:0]};
                    3:       value = {{8{value[23]}}, value[23:0]};
                    default: value = value;
                endcase
                res.read_data = value;
            end
            return res;
        endfunction

        function void note_request(input mem_request_t r);
            access_result_t res;
            bit             blank;
            res = translate(r, 1'b1, blank);
            awaiting_results.push_back(res);
            // remember good writes so that reads can revisit them
            if (r.req_type == ACCESS_WRITE && res.fault_code == FAULT_NONE
                && r.byte_count != 0)
            begin
                recent_writes.push_back(r);
                if (recent_writes.size() > HISTORY_DEPTH)
                    void'(recent_writes.pop_front());
            end
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_result(input logic [31:0] rd, input logic [16:0] pa,
                          input logic [1:0] fc);
            access_result_t want;
            if (awaiting_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = awaiting_results.pop_front();
            if (rd !== want.read_data)
                report_mismatch($sformatf("read_data %h, want %h", rd, want.read_data));
            if (pa !== want.phys_address)
                report_mismatch($sformatf("phys_address %h, want %h", pa,
                                          want.phys_address));
            if (fc !== want.fault_code)
                report_mismatch($sformatf("fault_code %0d, want %0d", fc,
                                          want.fault_code));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [15:0] segment;
    logic [15:0] offset;
    logic [15:0] byte_count;
    logic [31:0] write_data;
    logic        done;
    logic signed [31:0] read_data;
    logic [16:0] phys_address;
    logic [1:0]  fault_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [31:0] cfg_data;

    access_scoreboard sb;

    segmented_memory_access_unit_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .segment      (segment),
        .offset       (offset),
        .byte_count   (byte_count),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .phys_address (phys_address),
        .fault_code   (fault_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check each result in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_data, phys_address, fault_code);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("[segmented_memory_access_unit_top] ERROR");
        $finish;
    end

    function automatic mem_request_t access(input logic kind, input logic [15:0] sel,
                                            input logic [15:0] off, input logic [15:0] cnt,
                                            input logic [31:0] data);
        mem_request_t r;
        r.req_type   = kind;
        r.segment    = sel;
        r.offset     = off;
        r.byte_count = cnt;
        r.write_data = data;
        return r;
    endfunction

    function automatic logic [31:0] make_desc(input layout_t style);
        int unsigned base, size, roll;
        case (style)
            LAYOUT_SHARED:
            begin
                base = $urandom_range(0, 255);
                size = $urandom_range(64, 1024);
            end
            LAYOUT_EDGE:
            begin
                base = $urandom_range(MEM_BYTES - 512, MEM_BYTES - 1);
                size = $urandom_range(1, 1024);
            end
            LAYOUT_WILD:
            begin
                roll = $urandom_range(0, 4);
                if (roll == 0)
                    return 32'h0000_0000;
                if (roll == 1)
                    return 32'hFFFF_FFFF;
                if (roll == 2)
                    return $urandom();
                base = $urandom_range(0, MEM_BYTES - 1);
                size = $urandom_range(1, 512);
            end
            default:
            begin
                base = $urandom_range(0, MEM_BYTES - 1);
                size = $urandom_range(1, 512);
            end
        endcase
        return {base[15:0], size[15:0]};
    endfunction

    // Random request, biased towards live segments and reads of written bytes
    function automatic mem_request_t random_request();
        mem_request_t   r, prior;
        bit             blank;
        int unsigned    size, roll, cap;
        r.req_type   = ($urandom_range(0, 1) == 1) ? ACCESS_WRITE : ACCESS_READ;
        r.write_data = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 93)
            r.segment = 16'($urandom_range(0, SEG_COUNT - 1));
        else
            r.segment = 16'($urandom_range(0, 16'hFFFF));
        size = (r.segment < SEG_COUNT) ? 32'(sb.desc[r.segment][15:0]) : 0;
        roll = $urandom_range(0, 99);
        if (roll < 75 && size != 0)
            r.offset = 16'($urandom_range(0, size - 1));
        else if (roll < 88 && size != 0)
            r.offset = 16'(size - 1 + $urandom_range(0, 1));
        else
            r.offset = 16'($urandom_range(0, 16'hFFFF));
        roll = $urandom_range(0, 99);
        if (roll < 5)
            r.byte_count = 16'd0;
        else if (roll < 88)
            r.byte_count = 16'($urandom_range(1, MAX_BYTES));
        else
            r.byte_count = 16'($urandom_range(0, 16'hFFFF));
        // revisit a recent write for half of the reads
        if (r.req_type == ACCESS_READ && sb.recent_writes.size() != 0
            && $urandom_range(0, 1) == 1)
        begin
            prior = sb.recent_writes[$urandom_range(0, sb.recent_writes.size() - 1)];
            cap = (prior.byte_count > MAX_BYTES) ? MAX_BYTES : 32'(prior.byte_count);
            r.segment    = prior.segment;
            r.offset     = prior.offset;
            r.byte_count = 16'($urandom_range(0, cap));
        end
        // never read bytes that were never written: turn such a read into a write
        void'(sb.translate(r, 1'b0, blank));
        if (blank)
            r.req_type = ACCESS_WRITE;
        return r;
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input mem_request_t r);
        start      <= 1'b1;
        req_type   <= r.req_type;
        segment    <= r.segment;
        offset     <= r.offset;
        byte_count <= r.byte_count;
        write_data <= r.write_data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start, wait for every outstanding result, then let the block settle
    task automatic drain_requests();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaiting_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and hold valid; the caller drops it after the batch
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_desc(idx, value);
    endtask

    task automatic load_layout(input layout_t style);
        for (int seg = 0; seg < DESC_REGS; seg++)
            write_reg(8'(seg), make_desc(style));
        cfg_valid <= 1'b0;
    endtask

    // Directed pass: field extremes, sign extension, clamping and every fault
    task automatic directed_checks();
        write_reg(8'd0, {16'h0000, 16'h0100});
        write_reg(8'd1, {16'h3FFE, 16'h0010});
        write_reg(8'd2, {16'h0800, 16'h0000});
        write_reg(8'd3, 32'hFFFF_FFFF);
        write_reg(8'd4, {16'h1000, 16'hFFFF});
        write_reg(8'd5, 32'h0000_0000);
        write_reg(8'd6, {16'h0000, 16'h0001});
        write_reg(8'd7, {16'h2000, 16'h0040});
        // out-of-range indexes must leave the descriptors alone
        write_reg(STRAY_INDEX_LOW, $urandom());
        write_reg(STRAY_INDEX_HIGH, $urandom());
        cfg_valid <= 1'b0;

        // full word, then narrower reads with sign extension
        send_request(access(ACCESS_WRITE, 16'd0, 16'd0, 16'd4, 32'h80FF_0102));
        send_request(access(ACCESS_READ, 16'd0, 16'd0, 16'd4, 32'h0));
        send_request(access(ACCESS_READ, 16'd0, 16'd0, 16'd1, 32'h0));
        send_request(access(ACCESS_READ, 16'd0, 16'd1, 16'd2, 32'h0));
        send_request(access(ACCESS_READ, 16'd0, 16'd1, 16'd3, 32'h0));
        send_request(access(ACCESS_READ, 16'd0, 16'd2, 16'd0, 32'hFFFF_FFFF));
        // counts above four are clamped
        send_request(access(ACCESS_WRITE, 16'd0, 16'd4, 16'hFFFF, 32'h7F12_3456));
        send_request(access(ACCESS_READ, 16'd0, 16'd4, 16'd5, 32'h0));
        send_request(access(ACCESS_READ, 16'd0, 16'd5, 16'd3, 32'h0));
        // zero-count write stores nothing
        send_request(access(ACCESS_WRITE, 16'd0, 16'd8, 16'd0, 32'hFFFF_FFFF));
        // limit check uses the start offset only
        send_request(access(ACCESS_WRITE, 16'd0, 16'h00FF, 16'd2, 32'h0000_A5C3));
        send_request(access(ACCESS_READ, 16'd0, 16'h0100, 16'd1, 32'h0));
        // bad selectors
        send_request(access(ACCESS_READ, 16'd8, 16'd0, 16'd1, 32'h0));
        send_request(access(ACCESS_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(access(ACCESS_READ, 16'h8000, 16'd0, 16'd4, 32'h0));
        // zero-size segments always fault on the limit
        send_request(access(ACCESS_READ, 16'd2, 16'd0, 16'd1, 32'h0));
        send_request(access(ACCESS_WRITE, 16'd5, 16'd0, 16'd4, 32'h1234_5678));
        // accesses at and across the end of memory
        send_request(access(ACCESS_WRITE, 16'd1, 16'd1, 16'd1, 32'h0000_005A));
        send_request(access(ACCESS_WRITE, 16'd1, 16'd1, 16'd2, 32'h0000_BEEF));
        send_request(access(ACCESS_READ, 16'd1, 16'd2, 16'd0, 32'h0));
        send_request(access(ACCESS_WRITE, 16'd1, 16'd0, 16'd2, 32'h0000_1234));
        send_request(access(ACCESS_READ, 16'd1, 16'd0, 16'd2, 32'h0));
        send_request(access(ACCESS_READ, 16'd3, 16'hFFFE, 16'd1, 32'h0));
        send_request(access(ACCESS_READ, 16'd3, 16'hFFFF, 16'd4, 32'h0));
        send_request(access(ACCESS_READ, 16'd4, 16'h2FFE, 16'd4, 32'h0));
        // a multi-byte access may run past the limit when it starts inside
        send_request(access(ACCESS_WRITE, 16'd7, 16'h003F, 16'd4, 32'hC0FF_EE11));
        send_request(access(ACCESS_READ, 16'd7, 16'h003F, 16'd4, 32'h0));
        send_request(access(ACCESS_READ, 16'd6, 16'd0, 16'd1, 32'h0));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        layout_t plan [5];
        bit      quiet;
        plan = '{LAYOUT_SHARED, LAYOUT_COMPACT, LAYOUT_WILD, LAYOUT_EDGE, LAYOUT_SHARED};
        sb = new();
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= ACCESS_READ;
        segment    <= '0;
        offset     <= '0;
        byte_count <= '0;
        write_data <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        drain_requests();

        // random phases, one descriptor layout each
        for (int phase = 0; phase < 5; phase++)
        begin
            load_layout(plan[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                quiet = (phase == 4) && (n >= PHASE_ITEMS - QUIET_ITEMS);
                if (!quiet && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 8));
                // hold off mid-phase until every result is back
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_requests();
                send_request(random_request());
            end
            drain_requests();
        end

        if (sb.errors == 0)
            $display("[segmented_memory_access_unit_top] OK");
        else
            $display("[segmented_memory_access_unit_top] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/sma_pkg.sv
rtl/sma_ram.sv
rtl/sma_xlat.sv
rtl/sma_ctrl.sv
rtl/segmented_memory_access_unit_top.sv
rtl/sma_chk.sv
verif/testbench.sv
